@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the covariance unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// A condition that must never be seen on a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

@@ rtl/rwc_pkg.sv @@
// ----------------------------------------------------------------------------
// Covariance unit package
// Fixed widths, reset values and the control word of the shared arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rwc_pkg;

   // Result width and configuration register width are fixed by the interface.
   localparam int COV_W  = 50;
   localparam int WLEN_W = 9;
   localparam logic [WLEN_W-1:0] WLEN_RESET = 9'd10;

   typedef enum logic [3:0] {
      OP_IDLE,
      OP_LOAD_N,
      OP_ADD_STEP,
      OP_LOAD_XY,
      OP_SUB_STEP,
      OP_ABS,
      OP_DIV_STEP,
      OP_SAT,
      OP_NEG
   } alu_op_type;

   typedef struct packed {
      alu_op_type op;
      logic       sign_step;
   } alu_ctrl_type;

endpackage

`default_nettype wire

@@ rtl/rwc_window_mem.sv @@
// ----------------------------------------------------------------------------
// Window memory
// Circular store of sample pairs, one write and one registered read a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rwc_window_mem #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 48
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/rwc_alu.sv @@
// ----------------------------------------------------------------------------
// Covariance arithmetic unit
// One shared wide adder for shift-add products and the sign steps, and a
// restoring divider that retires one quotient bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rwc_alu import rwc_pkg::*; #(
   parameter int NW    = 9,
   parameter int SDW   = 34,
   parameter int SXY_W = 60,
   parameter int ACC_W = 71
) (
   input  logic                    clock,
   input  alu_ctrl_type            ctrl,
   input  logic [NW-1:0]           n,
   input  logic signed [SDW-1:0]   sum_dx,
   input  logic signed [SDW-1:0]   sum_dy,
   input  logic signed [SXY_W-1:0] sum_dxdy,
   output logic [COV_W-1:0]        result
);

   localparam int DDW = 2 * NW;
   localparam logic [ACC_W-1:0] LIM_POS = {{(ACC_W-COV_W+1){1'b0}}, {(COV_W-1){1'b1}}};
   localparam logic [ACC_W-1:0] LIM_NEG = {{(ACC_W-COV_W){1'b0}}, 1'b1, {(COV_W-1){1'b0}}};

   logic [ACC_W-1:0] acc_ff, acc_in;
   logic [ACC_W-1:0] mcand_ff, mcand_in;
   logic [SDW-1:0]   mplier_ff, mplier_in;
   logic [DDW:0]     rem_ff, rem_in;
   logic [DDW-1:0]   d_ff, d_in;
   logic             neg_ff, neg_in;

   // Shared adder.
   logic [ACC_W-1:0] add_a, add_b, add_sum, add_sel, lim;
   logic             add_sub;

   // Divider step.
   logic [DDW:0] rem_sh, rem_diff;
   logic         take;

   assign add_sel = mplier_ff[0] ? mcand_ff : '0;
   assign add_sum = add_a + (add_sub ? ~add_b : add_b) + ACC_W'(add_sub);

   assign rem_sh   = {rem_ff[DDW-1:0], acc_ff[ACC_W-1]};
   assign rem_diff = rem_sh - {1'b0, d_ff};
   assign take     = rem_sh >= {1'b0, d_ff};
   assign lim      = neg_ff ? LIM_NEG : LIM_POS;

   always_comb begin
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      rem_in    = rem_ff;
      d_in      = d_ff;
      neg_in    = neg_ff;
      add_a     = acc_ff;
      add_b     = add_sel;
      add_sub   = 1'b0;

      case (ctrl.op)
         OP_IDLE: begin
         end
         OP_LOAD_N: begin
            acc_in    = '0;
            mcand_in  = ACC_W'(sum_dxdy);
            mplier_in = SDW'(n);
            d_in      = DDW'(n) * DDW'(n - NW'(1));
         end
         OP_ADD_STEP: begin
            acc_in    = add_sum;
            mcand_in  = {mcand_ff[ACC_W-2:0], 1'b0};
            mplier_in = {1'b0, mplier_ff[SDW-1:1]};
         end
         OP_LOAD_XY: begin
            mcand_in  = ACC_W'(sum_dx);
            mplier_in = sum_dy;
         end
         OP_SUB_STEP: begin
            // The top bit of a two's complement multiplier weighs negative,
            // so the product is subtracted except on that step.
            add_sub   = !ctrl.sign_step;
            acc_in    = add_sum;
            mcand_in  = {mcand_ff[ACC_W-2:0], 1'b0};
            mplier_in = {1'b0, mplier_ff[SDW-1:1]};
         end
         OP_ABS: begin
            add_a   = '0;
            add_b   = acc_ff;
            add_sub = 1'b1;
            neg_in  = acc_ff[ACC_W-1];
            acc_in  = acc_ff[ACC_W-1] ? add_sum : acc_ff;
            rem_in  = '0;
         end
         OP_DIV_STEP: begin
            rem_in = take ? rem_diff : rem_sh;
            acc_in = {acc_ff[ACC_W-2:0], take};
         end
         OP_SAT: begin
            if (acc_ff > lim) begin
               acc_in = lim;
            end
         end
         OP_NEG: begin
            add_a   = '0;
            add_b   = acc_ff;
            add_sub = 1'b1;
            if (neg_ff) begin
               acc_in = add_sum;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      rem_ff    <= rem_in;
      d_ff      <= d_in;
      neg_ff    <= neg_in;
   end

   assign result = acc_ff[COV_W-1:0];

endmodule

`default_nettype wire

@@ rtl/rolling_window_covariance_unit.sv @@
// ----------------------------------------------------------------------------
// Rolling window covariance unit
// Sample covariance of the last n pairs of two signed series, exact in
// integers and truncated toward zero.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake             Carries
//   req_     in         req_valid/req_ready   sample_x, sample_y, restart
//   rsp_     out        rsp_valid/rsp_ready   covariance, valid_res
//   csr_     in         csr_valid/csr_ready   window_len
//
// A request whose window is full keeps the unit busy after acceptance while the
// shift-add multiplier on the shared adder and the bit-serial divider work out
// its result. Any other request only updates the running sums and the window.
// No new request is taken until the last one's response is handed over.
// A finished response waits in an output register while the next request is
// taken; the unit stalls only when a new response finds that register full.
// Reset is synchronous, holds both ready lines low, clears the sequencer and
// the window fill and sets the window length to ten. The memory needs no clearing.
//
`default_nettype none

`include "assert_macros.svh"

module rolling_window_covariance_unit import rwc_pkg::*; #(
   parameter int WINDOW_MAX  = 256,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_x,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_y,
   input  logic                          req_restart,

   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [COV_W-1:0]       rsp_covariance,
   output logic                          rsp_valid_res,

   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [WLEN_W-1:0]             csr_window_len
);

   // Width of a window length or fill count, and of a memory address.
   localparam int NW = $clog2(WINDOW_MAX + 1);
   localparam int AW = $clog2(WINDOW_MAX);
   // A shifted sample needs one bit more than the sample itself.
   localparam int DW = SAMPLE_BITS + 1;
   // Running sums carry headroom for a full window. The product sum wraps at
   // 64 bits when the parameters would need more.
   localparam int SDW     = SAMPLE_BITS + $clog2(WINDOW_MAX) + 2;
   localparam int SXY_RAW = 2 * SAMPLE_BITS + $clog2(WINDOW_MAX) + 4;
   localparam int SXY_W   = (SXY_RAW > 64) ? 64 : SXY_RAW;
   // The numerator n*sum_dxdy - sum_dx*sum_dy, kept wide enough to also
   // hold the saturation limits of the response.
   localparam int NUM_RAW = ((SXY_W + NW + 1 > 2 * SDW) ? SXY_W + NW + 1 : 2 * SDW) + 1;
   localparam int ACC_W   = (NUM_RAW > COV_W + 1) ? NUM_RAW : COV_W + 1;
   localparam int CW      = $clog2(ACC_W + 1);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_OLD_MUL,
      ST_OLD_ACC,
      ST_NEW_MUL,
      ST_NEW_ACC,
      ST_LOAD_N,
      ST_MUL_N,
      ST_LOAD_XY,
      ST_MUL_XY,
      ST_ABS,
      ST_DIV,
      ST_SAT,
      ST_NEG,
      ST_EMIT
   } state_type;

   state_type                  state_ff, state_in;
   logic [WLEN_W-1:0]          window_len_ff, window_len_in;
   logic                       have_ref_ff, have_ref_in;
   logic [NW-1:0]              fill_ff, fill_in;
   logic [AW-1:0]              wp_ff, wp_in;
   logic [NW-1:0]              n_ff, n_in;
   logic signed [SAMPLE_BITS-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [SAMPLE_BITS-1:0] ref_x_ff, ref_x_in, ref_y_ff, ref_y_in;
   logic signed [SDW-1:0]      sum_dx_ff, sum_dx_in, sum_dy_ff, sum_dy_in;
   logic signed [SXY_W-1:0]    sum_dxdy_ff, sum_dxdy_in;
   logic signed [2*DW-1:0]     prod_ff, prod_in;
   logic                       vres_ff, vres_in;
   logic [CW-1:0]              cnt_ff, cnt_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [COV_W-1:0]    rsp_cov_ff, rsp_cov_in;
   logic                       rsp_vres_ff, rsp_vres_in;

   logic [NW-1:0]              n_eff;
   logic [NW:0]                wp_ext, n_ext, old_idx;
   logic                       mem_rd_en, mem_wr_en;
   logic [2*SAMPLE_BITS-1:0]   mem_rd_data;
   logic signed [SAMPLE_BITS-1:0] old_x, old_y;
   logic signed [DW-1:0]       dx, dy, odx, ody, mul_a, mul_b;
   logic signed [2*DW-1:0]     prod_full;
   logic                       idle;
   alu_ctrl_type               alu_ctrl;
   logic [COV_W-1:0]           alu_result;

   // Window lengths below two act as two, those above the memory depth as
   // the full depth.
   always_comb begin
      if (window_len_ff < WLEN_W'(2)) begin
         n_eff = NW'(2);
      end else if (int'(window_len_ff) > WINDOW_MAX) begin
         n_eff = NW'(WINDOW_MAX);
      end else begin
         n_eff = NW'(window_len_ff);
      end
   end

   // The pair that leaves the window sits n entries behind the write pointer.
   assign wp_ext  = (NW+1)'(wp_ff);
   assign n_ext   = (NW+1)'(n_eff);
   assign old_idx = (wp_ext >= n_ext) ? wp_ext - n_ext
                                      : wp_ext + (NW+1)'(WINDOW_MAX) - n_ext;

   assign old_x = mem_rd_data[2*SAMPLE_BITS-1:SAMPLE_BITS];
   assign old_y = mem_rd_data[SAMPLE_BITS-1:0];

   assign dx  = DW'(x_ff) - DW'(ref_x_ff);
   assign dy  = DW'(y_ff) - DW'(ref_y_ff);
   assign odx = DW'(old_x) - DW'(ref_x_ff);
   assign ody = DW'(old_y) - DW'(ref_y_ff);

   // One multiplier serves both the leaving and the entering pair.
   assign mul_a     = (state_ff == ST_OLD_MUL) ? odx : dx;
   assign mul_b     = (state_ff == ST_OLD_MUL) ? ody : dy;
   assign prod_full = mul_a * mul_b;

   assign idle      = (state_ff == ST_IDLE);
   assign csr_ready = idle && !reset;
   // A register write on the same cycle wins over a request.
   assign req_ready = idle && !reset && !csr_valid;

   rwc_window_mem #(
      .DEPTH (WINDOW_MAX),
      .WIDTH (2 * SAMPLE_BITS)
   ) u_window (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (wp_ff),
      .wr_data ({x_ff, y_ff}),
      .rd_en   (mem_rd_en),
      .rd_addr (old_idx[AW-1:0]),
      .rd_data (mem_rd_data)
   );

   rwc_alu #(
      .NW    (NW),
      .SDW   (SDW),
      .SXY_W (SXY_W),
      .ACC_W (ACC_W)
   ) u_alu (
      .clock    (clock),
      .ctrl     (alu_ctrl),
      .n        (n_ff),
      .sum_dx   (sum_dx_ff),
      .sum_dy   (sum_dy_ff),
      .sum_dxdy (sum_dxdy_ff),
      .result   (alu_result)
   );

   always_comb begin
      state_in      = state_ff;
      window_len_in = window_len_ff;
      have_ref_in   = have_ref_ff;
      fill_in       = fill_ff;
      wp_in         = wp_ff;
      n_in          = n_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      ref_x_in      = ref_x_ff;
      ref_y_in      = ref_y_ff;
      sum_dx_in     = sum_dx_ff;
      sum_dy_in     = sum_dy_ff;
      sum_dxdy_in   = sum_dxdy_ff;
      prod_in       = prod_ff;
      vres_in       = vres_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_cov_in    = rsp_cov_ff;
      rsp_vres_in   = rsp_vres_ff;
      mem_rd_en     = 1'b0;
      mem_wr_en     = 1'b0;
      alu_ctrl.op        = OP_IDLE;
      alu_ctrl.sign_step = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (csr_valid && csr_ready) begin
               // A new window length ends the series.
               window_len_in = csr_window_len;
               have_ref_in   = 1'b0;
               fill_in       = '0;
            end else if (req_valid && req_ready) begin
               x_in      = req_sample_x;
               y_in      = req_sample_y;
               n_in      = n_eff;
               mem_rd_en = 1'b1;
               if (req_restart || !have_ref_ff) begin
                  // This pair becomes the shift reference of a new series.
                  ref_x_in    = req_sample_x;
                  ref_y_in    = req_sample_y;
                  sum_dx_in   = '0;
                  sum_dy_in   = '0;
                  sum_dxdy_in = '0;
                  fill_in     = '0;
                  wp_in       = '0;
                  have_ref_in = 1'b1;
                  state_in    = ST_NEW_MUL;
               end else if (fill_ff >= n_eff) begin
                  state_in = ST_OLD_MUL;
               end else begin
                  state_in = ST_NEW_MUL;
               end
            end
         end
         ST_OLD_MUL: begin
            prod_in   = prod_full;
            sum_dx_in = sum_dx_ff - SDW'(odx);
            sum_dy_in = sum_dy_ff - SDW'(ody);
            state_in  = ST_OLD_ACC;
         end
         ST_OLD_ACC: begin
            sum_dxdy_in = sum_dxdy_ff - SXY_W'(prod_ff);
            state_in    = ST_NEW_MUL;
         end
         ST_NEW_MUL: begin
            prod_in   = prod_full;
            sum_dx_in = sum_dx_ff + SDW'(dx);
            sum_dy_in = sum_dy_ff + SDW'(dy);
            mem_wr_en = 1'b1;
            state_in  = ST_NEW_ACC;
         end
         ST_NEW_ACC: begin
            sum_dxdy_in = sum_dxdy_ff + SXY_W'(prod_ff);
            wp_in = (wp_ff == AW'(WINDOW_MAX - 1)) ? '0 : wp_ff + AW'(1);
            if (fill_ff < n_ff) begin
               fill_in = fill_ff + NW'(1);
            end
            // The window is full once this pair brings the count up to n.
            if (fill_ff >= n_ff - NW'(1)) begin
               vres_in  = 1'b1;
               state_in = ST_LOAD_N;
            end else begin
               vres_in  = 1'b0;
               state_in = ST_EMIT;
            end
         end
         ST_LOAD_N: begin
            alu_ctrl.op = OP_LOAD_N;
            cnt_in      = CW'(NW - 1);
            state_in    = ST_MUL_N;
         end
         ST_MUL_N: begin
            alu_ctrl.op = OP_ADD_STEP;
            cnt_in      = cnt_ff - CW'(1);
            if (cnt_ff == '0) begin
               state_in = ST_LOAD_XY;
            end
         end
         ST_LOAD_XY: begin
            alu_ctrl.op = OP_LOAD_XY;
            cnt_in      = CW'(SDW - 1);
            state_in    = ST_MUL_XY;
         end
         ST_MUL_XY: begin
            alu_ctrl.op        = OP_SUB_STEP;
            alu_ctrl.sign_step = (cnt_ff == '0);
            cnt_in             = cnt_ff - CW'(1);
            if (cnt_ff == '0) begin
               state_in = ST_ABS;
            end
         end
         ST_ABS: begin
            alu_ctrl.op = OP_ABS;
            cnt_in      = CW'(ACC_W - 1);
            state_in    = ST_DIV;
         end
         ST_DIV: begin
            alu_ctrl.op = OP_DIV_STEP;
            cnt_in      = cnt_ff - CW'(1);
            if (cnt_ff == '0) begin
               state_in = ST_SAT;
            end
         end
         ST_SAT: begin
            alu_ctrl.op = OP_SAT;
            state_in    = ST_NEG;
         end
         ST_NEG: begin
            alu_ctrl.op = OP_NEG;
            state_in    = ST_EMIT;
         end
         ST_EMIT: begin
            // Hand the response over once the output register is free.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_cov_in   = vres_ff ? alu_result : '0;
               rsp_vres_in  = vres_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         window_len_ff <= WLEN_RESET;
         have_ref_ff   <= 1'b0;
         fill_ff       <= '0;
         wp_ff         <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         window_len_ff <= window_len_in;
         have_ref_ff   <= have_ref_in;
         fill_ff       <= fill_in;
         wp_ff         <= wp_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      n_ff        <= n_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      ref_x_ff    <= ref_x_in;
      ref_y_ff    <= ref_y_in;
      sum_dx_ff   <= sum_dx_in;
      sum_dy_ff   <= sum_dy_in;
      sum_dxdy_ff <= sum_dxdy_in;
      prod_ff     <= prod_in;
      vres_ff     <= vres_in;
      cnt_ff      <= cnt_in;
      rsp_cov_ff  <= rsp_cov_in;
      rsp_vres_ff <= rsp_vres_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_covariance = rsp_cov_ff;
   assign rsp_valid_res  = rsp_vres_ff;

   // Only one request is in flight at a time.
   `ASSERT_IMPL(a_busy_after_accept, clock, reset, (req_valid && req_ready) |=> !req_ready, "request accepted while another was in flight")
   // The fill count never runs past the window length.
   `ASSERT_NEVER(a_fill_bound, clock, reset, fill_ff > n_eff, "fill count exceeds the window length")
   // A response without a full window carries a zero covariance.
   `ASSERT_IMPL(a_zero_when_invalid, clock, reset, (rsp_valid && !rsp_valid_res) |-> (rsp_covariance == '0), "invalid response carries a nonzero covariance")
   // A finished response waits while the output register is still held.
   `ASSERT_IMPL(a_emit_waits, clock, reset, ((state_ff == ST_EMIT) && rsp_valid && !rsp_ready) |=> (state_ff == ST_EMIT), "response dropped while the output register was full")

endmodule

`default_nettype wire
